// ----- hw/rtl/image_stencil_filter_5x5_unit_defines.svh -----
// Assertion macros for the 5x5 stencil filter unit.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef IMAGE_STENCIL_FILTER_5X5_UNIT_DEFINES_SVH
`define IMAGE_STENCIL_FILTER_5X5_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define ISF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ISF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/isf_pkg.sv -----
// Shared constants and types for the 5x5 stencil filter unit.
// No dependencies.
package isf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = 19;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 5;
    localparam int LINES       = 4;
    localparam int LINE_AW     = $clog2(MAX_WIDTH);
    localparam int WORD_W      = LINES * SAMPLE_W;

    // Gaussian datapath widths
    localparam int SUM_W       = 25;   // signed weighted sum
    localparam int MAG_W       = 24;   // magnitude plus rounding offset
    localparam int QUO_W       = 16;   // quotient magnitude
    localparam int PROD_W      = 2 * MAG_W;
    localparam int RECIP_SHIFT = 32;

    localparam int GAUSS_DIV   = 273;
    localparam int GAUSS_RND   = 136;
    // floor(2^32 / 273): estimate is exact or one short
    localparam logic [MAG_W-1:0] GAUSS_RECIP = MAG_W'(15732480);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(2);

    localparam logic MODE_LAPLACE = 1'b0;
    localparam logic MODE_GAUSS   = 1'b1;

    typedef logic [SAMPLE_W-1:0] pix_t;
    typedef pix_t [4:0]          win_row_t;
    typedef win_row_t [4:0]      window_t;   // [row][col], row 0 oldest

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

    typedef struct packed {
        logic shift;   // window shift and line store write-back
        logic en_c;    // group-sum stage load
        logic en_d;    // weighted-sum stage load
    } win_ctrl_t;

endpackage

// ----- hw/rtl/isf_line_window.sv -----
// Line store memory (four rows packed per word) and the 5x5 window registers.
// Depends on isf_pkg.
module isf_line_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [isf_pkg::LINE_AW-1:0]   rd_addr,
    input  logic                          shift_en,
    input  logic [isf_pkg::LINE_AW-1:0]   wr_addr,
    input  isf_pkg::pix_t                 new_sample,
    output isf_pkg::window_t              window
);
    import isf_pkg::*;

    logic [WORD_W-1:0] mem [MAX_WIDTH];
    logic [WORD_W-1:0] rd_q_reg;
    window_t           window_reg;
    window_t           window_next;

    // word: [15:0] newest line ... [63:48] oldest line
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
        if (shift_en)
        begin
            mem[wr_addr] <= {rd_q_reg[WORD_W-SAMPLE_W-1:0], new_sample};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                window_next[i][j] = window_reg[i][j+1];
            end
        end
        for (int i = 0; i < LINES; i++)
        begin
            window_next[i][4] = rd_q_reg[(LINES-1-i)*SAMPLE_W +: SAMPLE_W];
        end
        window_next[4][4] = new_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (shift_en)
        begin
            window_reg <= window_next;
        end
    end

    assign window = window_reg;

endmodule

// ----- hw/rtl/isf_stencil.sv -----
// Stencil arithmetic: symmetric group sums, then Laplacian and Gaussian sums.
// Depends on isf_pkg.
module isf_stencil (
    input  logic                              clk,
    input  isf_pkg::window_t                  window,
    input  isf_pkg::win_ctrl_t                ctrl,
    output logic signed [isf_pkg::OUT_W-1:0]  lap,
    output logic signed [isf_pkg::SUM_W-1:0]  gsum
);
    import isf_pkg::*;

    logic signed [SAMPLE_W-1:0] p [5][5];

    logic signed [SAMPLE_W-1:0] centre_reg;
    logic signed [17:0]         direct_reg, diag_reg, axis_reg, corner_reg;
    logic signed [18:0]         knight_reg;
    logic signed [OUT_W-1:0]    lap_reg;
    logic signed [SUM_W-1:0]    gsum_reg;

    logic signed [17:0]         direct_next, diag_next, axis_next, corner_next;
    logic signed [18:0]         knight_next;
    logic signed [SUM_W-1:0]    gsum_next;

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            for (int j = 0; j < 5; j++)
            begin
                p[i][j] = $signed(window[i][j]);
            end
        end
    end

    always_comb
    begin
        direct_next = 18'(p[3][2]) + 18'(p[1][2]) + 18'(p[2][3]) + 18'(p[2][1]);
        diag_next   = 18'(p[3][3]) + 18'(p[1][3]) + 18'(p[3][1]) + 18'(p[1][1]);
        axis_next   = 18'(p[4][2]) + 18'(p[0][2]) + 18'(p[2][4]) + 18'(p[2][0]);
        corner_next = 18'(p[4][4]) + 18'(p[0][4]) + 18'(p[4][0]) + 18'(p[0][0]);
        knight_next = 19'(p[4][3]) + 19'(p[3][4]) + 19'(p[0][3]) + 19'(p[1][4])
                    + 19'(p[4][1]) + 19'(p[3][0]) + 19'(p[0][1]) + 19'(p[1][0]);
    end

    // stage C: group sums and the Laplacian
    always_ff @(posedge clk)
    begin
        if (ctrl.en_c)
        begin
            centre_reg <= p[2][2];
            direct_reg <= direct_next;
            diag_reg   <= diag_next;
            axis_reg   <= axis_next;
            corner_reg <= corner_next;
            knight_reg <= knight_next;
            lap_reg    <= OUT_W'(direct_next) - (OUT_W'(p[2][2]) <<< 2);
        end
    end

    always_comb
    begin
        gsum_next = SUM_W'(centre_reg) * SUM_W'(41)
                  + SUM_W'(direct_reg) * SUM_W'(26)
                  + (SUM_W'(diag_reg) <<< 4)
                  + SUM_W'(axis_reg) * SUM_W'(7)
                  + (SUM_W'(knight_reg) <<< 2)
                  + SUM_W'(corner_reg);
    end

    // stage D: weighted Gaussian sum
    always_ff @(posedge clk)
    begin
        if (ctrl.en_d)
        begin
            gsum_reg <= gsum_next;
        end
    end

    assign lap  = lap_reg;
    assign gsum = gsum_reg;

endmodule

// ----- hw/rtl/isf_div273.sv -----
// Signed divide by 273, rounded half away from zero, by reciprocal multiply.
// Depends on isf_pkg. Two register stages; the correction step is combinational.
module isf_div273 (
    input  logic                              clk,
    input  logic                              en_e,
    input  logic                              en_f,
    input  logic signed [isf_pkg::SUM_W-1:0]  gsum,
    output logic signed [isf_pkg::OUT_W-1:0]  quot
);
    import isf_pkg::*;

    logic              neg_e_reg, neg_f_reg;
    logic [MAG_W-1:0]  mag_e_reg, mag_f_reg;
    logic [QUO_W-1:0]  q0_f_reg;

    logic [SUM_W-1:0]  abs_val;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  rem;
    logic [QUO_W-1:0]  q;
    logic [OUT_W-1:0]  q_ext;

    assign abs_val = gsum[SUM_W-1] ? SUM_W'(-gsum) : SUM_W'(gsum);

    // stage E: sign and rounded magnitude
    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            neg_e_reg <= gsum[SUM_W-1];
            mag_e_reg <= abs_val[MAG_W-1:0] + MAG_W'(GAUSS_RND);
        end
    end

    assign prod = PROD_W'(mag_e_reg) * PROD_W'(GAUSS_RECIP);

    // stage F: quotient estimate, exact or one short
    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            neg_f_reg <= neg_e_reg;
            mag_f_reg <= mag_e_reg;
            q0_f_reg  <= prod[RECIP_SHIFT +: QUO_W];
        end
    end

    assign rem   = mag_f_reg - MAG_W'(MAG_W'(q0_f_reg) * MAG_W'(GAUSS_DIV));
    assign q     = (rem >= MAG_W'(GAUSS_DIV)) ? q0_f_reg + QUO_W'(1) : q0_f_reg;
    assign q_ext = OUT_W'(q);
    assign quot  = neg_f_reg ? $signed(-q_ext) : $signed(q_ext);

endmodule

// ----- hw/rtl/image_stencil_filter_5x5_unit.sv -----
// Top level of the 5x5 stencil filter unit (Laplacian or 273-weight Gaussian).
// Depends on isf_pkg, isf_line_window, isf_stencil, isf_div273 and the defines header.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------------------
//   sample   | sample_valid / sample_stall | sample
//   result   | result_valid / result_stall | filtered, center_row, center_col, frame_last
//   config   | cfg_we (no stall)           | cfg_index, cfg_data
//
// One sample per clock sustained while no stall holds the chain. The transfer edge
// issues the line store read and loads the first stage; window shift, group sums,
// weighted sum, two divider stages and the output register follow in that order.
// Reset clears counters, config registers, window, every stage valid, but not the line
// store or payloads. Stall is combinational down the stage chain: bubbles
// close up, and sample_stall rises only with every stage full and the result stalled.
`include "image_stencil_filter_5x5_unit_defines.svh"

module image_stencil_filter_5x5_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [isf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [isf_pkg::SAMPLE_W-1:0] sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [isf_pkg::OUT_W-1:0]    filtered,
    output logic [isf_pkg::ROW_W-1:0]           center_row,
    output logic [isf_pkg::COL_W-1:0]           center_col,
    output logic                                frame_last
);
    import isf_pkg::*;

    // configuration
    logic                mode_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_next;
    logic [HEIGHT_W-1:0] height_next;
    logic                geom_write;

    // raster position of the next sample
    logic [ROW_W-1:0]    row_count_reg, row_count_next;
    logic [COL_W-1:0]    col_count_reg, col_count_next;
    logic                col_wrap, row_wrap, emit, last;
    logic                at_origin, centre_ok;

    // stage valids and per-stage readiness
    logic s1_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, out_v_reg;
    logic rdy_out, rdy_f, rdy_e, rdy_d, rdy_c, rdy_b, rdy_1;
    logic accept;

    // stage payloads
    pix_t                 s1_sample_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic                 s1_emit_reg;
    meta_t                s1_meta_reg, b_meta_reg, c_meta_reg, d_meta_reg;
    meta_t                e_meta_reg, f_meta_reg, out_meta_reg;
    meta_t                meta_next;
    logic signed [OUT_W-1:0] lap_d_reg, lap_e_reg, lap_f_reg, filtered_reg;

    window_t                 window;
    win_ctrl_t               wctrl;
    logic signed [OUT_W-1:0] lap_c;
    logic signed [SUM_W-1:0] gsum_d;
    logic signed [OUT_W-1:0] quot_f;

    // ---------------------------------------------------------------
    // Configuration: geometry saturates to the legal range and
    // restarts the frame at row 0, column 0.
    // ---------------------------------------------------------------
    always_comb
    begin
        width_next = cfg_data[WIDTH_W-1:0];
        if (width_next < WIDTH_W'(MIN_DIM))
        begin
            width_next = WIDTH_W'(MIN_DIM);
        end
        else if (width_next > WIDTH_W'(MAX_WIDTH))
        begin
            width_next = WIDTH_W'(MAX_WIDTH);
        end
        height_next = cfg_data[HEIGHT_W-1:0];
        if (height_next < HEIGHT_W'(MIN_DIM))
        begin
            height_next = HEIGHT_W'(MIN_DIM);
        end
        else if (height_next > HEIGHT_W'(MAX_HEIGHT))
        begin
            height_next = HEIGHT_W'(MAX_HEIGHT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_LAPLACE;
            width_reg  <= WIDTH_W'(MAX_WIDTH);
            height_reg <= HEIGHT_W'(MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_WIDTH:  width_reg  <= width_next;
                REG_HEIGHT: height_reg <= height_next;
                default:    ;
            endcase
        end
    end

    assign geom_write = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    // ---------------------------------------------------------------
    // Handshake: each stage may load when it is empty or its
    // occupant moves on, so bubbles close up within the cycle.
    // ---------------------------------------------------------------
    assign rdy_out      = !out_v_reg || !result_stall;
    assign rdy_f        = !f_v_reg   || rdy_out;
    assign rdy_e        = !e_v_reg   || rdy_f;
    assign rdy_d        = !d_v_reg   || rdy_e;
    assign rdy_c        = !c_v_reg   || rdy_d;
    assign rdy_b        = !b_v_reg   || rdy_c;
    assign rdy_1        = !s1_v_reg  || rdy_b;
    assign sample_stall = !rdy_1;
    assign accept       = sample_valid && rdy_1;

    // ---------------------------------------------------------------
    // Raster counters and result tagging at transfer time
    // ---------------------------------------------------------------
    assign col_wrap = (WIDTH_W'(col_count_reg) + WIDTH_W'(1)) >= width_reg;
    assign row_wrap = (HEIGHT_W'(row_count_reg) + HEIGHT_W'(1)) >= height_reg;
    assign last     = col_wrap && row_wrap;
    assign emit     = (row_count_reg >= ROW_W'(4)) && (col_count_reg >= COL_W'(4));

    always_comb
    begin
        col_count_next = col_count_reg + COL_W'(1);
        row_count_next = row_count_reg;
        if (col_wrap)
        begin
            col_count_next = '0;
            row_count_next = row_wrap ? '0 : row_count_reg + ROW_W'(1);
        end
        meta_next.row  = row_count_reg - ROW_W'(2);
        meta_next.col  = col_count_reg - COL_W'(2);
        meta_next.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (geom_write)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (accept)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline valids. Items without a result are dropped once they
    // have shifted the window.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            e_v_reg   <= 1'b0;
            f_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy_1)
            begin
                s1_v_reg <= accept;
            end
            if (rdy_b)
            begin
                b_v_reg <= s1_v_reg && s1_emit_reg;
            end
            if (rdy_c)
            begin
                c_v_reg <= b_v_reg;
            end
            if (rdy_d)
            begin
                d_v_reg <= c_v_reg;
            end
            if (rdy_e)
            begin
                e_v_reg <= d_v_reg;
            end
            if (rdy_f)
            begin
                f_v_reg <= e_v_reg;
            end
            if (rdy_out)
            begin
                out_v_reg <= f_v_reg;
            end
        end
    end

    // payload registers follow their stage's load enable
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_col_reg    <= col_count_reg;
            s1_emit_reg   <= emit;
            s1_meta_reg   <= meta_next;
        end
        if (rdy_b)
        begin
            b_meta_reg <= s1_meta_reg;
        end
        if (rdy_c)
        begin
            c_meta_reg <= b_meta_reg;
        end
        if (rdy_d)
        begin
            d_meta_reg <= c_meta_reg;
            lap_d_reg  <= lap_c;
        end
        if (rdy_e)
        begin
            e_meta_reg <= d_meta_reg;
            lap_e_reg  <= lap_d_reg;
        end
        if (rdy_f)
        begin
            f_meta_reg <= e_meta_reg;
            lap_f_reg  <= lap_e_reg;
        end
        if (rdy_out)
        begin
            out_meta_reg <= f_meta_reg;
            filtered_reg <= (mode_reg == MODE_GAUSS) ? quot_f : lap_f_reg;
        end
    end

    // ---------------------------------------------------------------
    // Datapath units
    // ---------------------------------------------------------------
    assign wctrl.shift = s1_v_reg && rdy_b;
    assign wctrl.en_c  = rdy_c;
    assign wctrl.en_d  = rdy_d;

    isf_line_window u_line_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (col_count_reg),
        .shift_en   (wctrl.shift),
        .wr_addr    (s1_col_reg),
        .new_sample (s1_sample_reg),
        .window     (window)
    );

    isf_stencil u_stencil (
        .clk    (clk),
        .window (window),
        .ctrl   (wctrl),
        .lap    (lap_c),
        .gsum   (gsum_d)
    );

    isf_div273 u_div273 (
        .clk  (clk),
        .en_e (rdy_e),
        .en_f (rdy_f),
        .gsum (gsum_d),
        .quot (quot_f)
    );

    assign result_valid = out_v_reg;
    assign filtered     = filtered_reg;
    assign center_row   = out_meta_reg.row;
    assign center_col   = out_meta_reg.col;
    assign frame_last   = out_meta_reg.last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    assign at_origin = (row_count_reg == '0) && (col_count_reg == '0);
    assign centre_ok = (center_row >= ROW_W'(2)) && (center_col >= COL_W'(2));

    `ISF_ASSERT_IMP(a_stall_needs_item, sample_stall, s1_v_reg, "stall with first stage empty")
    `ISF_ASSERT_NEXT(a_geom_restart, geom_write, at_origin, "geometry write kept position")
    `ISF_ASSERT_IMP(a_centre_inside, result_valid, centre_ok, "result centre on border")

endmodule

// ----- tb/tb_image_stencil_filter_5x5_unit.sv -----
// Self-checking testbench for the 5x5 stencil filter unit (Laplacian / 273-weight Gaussian).
// Depends on isf_pkg and the image_stencil_filter_5x5_unit RTL; carries its own filter predictor.
module tb_image_stencil_filter_5x5_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import isf_pkg::*;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    localparam int RANDOM_ITEMS  = 1250;
    // Pipeline is seven deep; allow for stall ripple and border samples that give no result
    localparam int SETTLE_CYCLES = 32;
    // Slowest correct run is roughly 2k transfers; the limit allows about 5x its length
    localparam int CYCLE_LIMIT   = 250000;
    localparam int REPORT_CAP    = 100;

    typedef logic signed [SAMPLE_W-1:0] pixel_t;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic                    last;
    } stencil_res_t;

    // DUT connections
    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [CFG_W-1:0]           cfg_data     = '0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample       = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [OUT_W-1:0]    filtered;
    logic [ROW_W-1:0]           center_row;
    logic [COL_W-1:0]           center_col;
    logic                       frame_last;

    // Pixels still to be offered, and filter results still owed by the DUT
    pixel_t       pixel_queue[$];
    stencil_res_t stencil_q[$];

    // Predictor state: mirror of the registers, line stores, window and raster position
    logic             img_mode;
    int               img_width;
    int               img_height;
    pixel_t           line_mem [0:LINES-1][0:MAX_WIDTH-1];
    pixel_t           win [0:4][0:4];
    int               row_ctr;
    int               col_ctr;

    // Run bookkeeping
    int errors        = 0;
    int pixels_moved  = 0;
    int results_seen  = 0;
    int phases        = 0;
    int cycles        = 0;
    int random_sent   = 0;

    // Handshake pacing
    int snd_wait  = 0;
    bit snd_burst = 1'b0;
    int rcv_wait  = 0;
    bit rcv_burst = 1'b0;

    image_stencil_filter_5x5_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .center_row   (center_row),
        .center_col   (center_col),
        .frame_last   (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Filter predictor
    // ------------------------------------------------------------------

    function automatic longint px(input int dy, input int dx);
        return longint'(win[2 + dy][2 + dx]);
    endfunction

    // Symmetric 273 kernel: weight depends only on the two axis distances
    function automatic longint gauss_weight(input int ay, input int ax);
        int lo;
        int hi;
        lo = (ay < ax) ? ay : ax;
        hi = (ay < ax) ? ax : ay;
        if (lo == 0 && hi == 0)
            return 41;
        else if (lo == 0 && hi == 1)
            return 26;
        else if (lo == 1 && hi == 1)
            return 16;
        else if (lo == 0 && hi == 2)
            return 7;
        else if (lo == 1 && hi == 2)
            return 4;
        return 1;
    endfunction

    function automatic longint gauss_273();
        longint acc;
        longint mag;
        longint quo;
        acc = 0;
        for (int dy = -2; dy <= 2; dy++)
            for (int dx = -2; dx <= 2; dx++)
                acc += gauss_weight(dy < 0 ? -dy : dy, dx < 0 ? -dx : dx) * px(dy, dx);
        // round to nearest, halves away from zero (273 is odd, so no exact halves)
        mag = (acc < 0) ? -acc : acc;
        quo = (mag + GAUSS_RND) / GAUSS_DIV;
        return (acc < 0) ? -quo : quo;
    endfunction

    function automatic longint laplacian_5pt();
        return -4 * px(0, 0) + px(-1, 0) + px(1, 0) + px(0, -1) + px(0, 1);
    endfunction

    // One accepted pixel: roll line stores and window, push the result it completes
    task automatic stencil_step(input pixel_t pix);
        pixel_t       column [0:4];
        stencil_res_t res;
        longint       v;
        int           c;
        int           r;
        c = col_ctr;
        r = row_ctr;
        column[0] = line_mem[3][c];
        column[1] = line_mem[2][c];
        column[2] = line_mem[1][c];
        column[3] = line_mem[0][c];
        column[4] = pix;
        line_mem[3][c] = line_mem[2][c];
        line_mem[2][c] = line_mem[1][c];
        line_mem[1][c] = line_mem[0][c];
        line_mem[0][c] = pix;
        for (int i = 0; i < 5; i++)
        begin
            for (int j = 0; j < 4; j++)
                win[i][j] = win[i][j + 1];
            win[i][4] = column[i];
        end
        if (r >= 4 && c >= 4)
        begin
            v = (img_mode == MODE_GAUSS) ? gauss_273() : laplacian_5pt();
            res.value = OUT_W'(v);
            res.row   = ROW_W'(r - 2);
            res.col   = COL_W'(c - 2);
            res.last  = (r + 1 >= img_height) && (c + 1 >= img_width);
            stencil_q.push_back(res);
        end
        c++;
        if (c >= img_width)
        begin
            c = 0;
            r++;
            if (r >= img_height)
                r = 0;
        end
        col_ctr = c;
        row_ctr = r;
    endtask

    // ------------------------------------------------------------------
    // Sample driver: one pixel per transfer, random gap after each
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                stencil_step(sample);
                pixels_moved++;
            end
            if (sample_valid && sample_stall)
            begin
                // stalled: hold valid and payload as they are
            end
            else if (snd_wait > 0)
            begin
                snd_wait--;
                sample_valid <= 1'b0;
            end
            else if (pixel_queue.size() != 0)
            begin
                sample       <= pixel_queue.pop_front();
                sample_valid <= 1'b1;
                if ($urandom_range(0, 47) == 0)
                    snd_burst = !snd_burst;
                snd_wait = snd_burst ? 0 : $urandom_range(0, 10);
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each transfer, then stalls for a drawn time
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stencil_res_t exp_res;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (stencil_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: unexpected result: expected none, got %0d (%0d,%0d) last=%0b",
                                 $time, filtered, center_row, center_col, frame_last);
                end
                else
                begin
                    exp_res = stencil_q.pop_front();
                    if (filtered !== exp_res.value || center_row !== exp_res.row ||
                        center_col !== exp_res.col || frame_last !== exp_res.last)
                    begin
                        errors++;
                        // keep the log short if the DUT is badly off
                        if (errors <= REPORT_CAP)
                            $display("%0t: expected %0d (%0d,%0d) last=%0b, got %0d (%0d,%0d) last=%0b",
                                     $time, exp_res.value, exp_res.row, exp_res.col, exp_res.last,
                                     filtered, center_row, center_col, frame_last);
                    end
                end
                if ($urandom_range(0, 47) == 0)
                    rcv_burst = !rcv_burst;
                rcv_wait = rcv_burst ? 0 : $urandom_range(0, 10);
            end
            if (rcv_wait > 0)
            begin
                rcv_wait--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit, %0d results still awaited",
                     $time, stencil_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Register write while the DUT is idle; the predictor follows at the same edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        int dim;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:
                img_mode = data[0];
            REG_WIDTH:
            begin
                dim = int'(data[WIDTH_W-1:0]);
                if (dim < MIN_DIM)   dim = MIN_DIM;
                if (dim > MAX_WIDTH) dim = MAX_WIDTH;
                img_width = dim;
                row_ctr   = 0;
                col_ctr   = 0;
            end
            REG_HEIGHT:
            begin
                dim = int'(data[HEIGHT_W-1:0]);
                if (dim < MIN_DIM)    dim = MIN_DIM;
                if (dim > MAX_HEIGHT) dim = MAX_HEIGHT;
                img_height = dim;
                row_ctr    = 0;
                col_ctr    = 0;
            end
            default:
            begin
                // unused index: no effect
            end
        endcase
        @(negedge clk);
    endtask

    // Every pixel transferred, every result in, then let border pixels clear the pipe
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || sample_valid || stencil_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        phases++;
    endtask

    // Mix of full-range noise, rail values and small values near zero
    function automatic pixel_t draw_pixel();
        case ($urandom_range(0, 7))
            0:       return pixel_t'(16'h8000);
            1:       return pixel_t'(16'h7FFF);
            2:       return pixel_t'(16'hFFFF);
            3, 4:    return pixel_t'($urandom_range(0, 600) - 300);
            default: return pixel_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int n_items;
        int half;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        bit   geometry_set;
        pixel_t pix;

        // predictor reset state
        img_mode   = MODE_LAPLACE;
        img_width  = MAX_WIDTH;
        img_height = MAX_HEIGHT;
        row_ctr    = 0;
        col_ctr    = 0;
        for (int i = 0; i < LINES; i++)
            for (int j = 0; j < MAX_WIDTH; j++)
                line_mem[i][j] = '0;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                win[i][j] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry (1024 wide, 4096 tall): a short run inside row 0 gives no result
        for (int k = 0; k < 48; k++)
            pixel_queue.push_back(draw_pixel());
        wait_drained();

        // 32 wide, 6 tall, mode left at reset (Laplacian). A negative Laplacian
        // peak is planted around row 2, column 10.
        write_reg(REG_WIDTH, CFG_W'(32));
        write_reg(REG_HEIGHT, CFG_W'(6));
        for (int r = 0; r < 6; r++)
            for (int c = 0; c < 32; c++)
            begin
                if (r == 2 && c == 10)
                    pix = pixel_t'(16'h7FFF);
                else if ((r == 2 && (c == 9 || c == 11)) || ((r == 1 || r == 3) && c == 10))
                    pix = pixel_t'(16'h8000);
                else
                    pix = draw_pixel();
                pixel_queue.push_back(pix);
            end
        wait_drained();

        // Out-of-range geometry saturates: width 0 -> 5, height 8191 -> 4096.
        // All-zero and all-ones data words, the spare index, Gaussian selected.
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, '1);
        write_reg(REG_MODE, '1);
        write_reg(REG_SPARE, '1);
        // Five rows at each rail give the Gaussian extremes
        for (int r = 0; r < 12; r++)
            for (int c = 0; c < MIN_DIM; c++)
            begin
                if (r < 5)
                    pix = pixel_t'(16'h7FFF);
                else if (r < 10)
                    pix = pixel_t'(16'h8000);
                else
                    pix = draw_pixel();
                pixel_queue.push_back(pix);
            end
        wait_drained();

        // Smallest width, 6 rows. Positive Laplacian peak at (2,2), then the mode is
        // switched mid-frame so the frame's last result comes out of the Gaussian.
        write_reg(REG_WIDTH, CFG_W'(MIN_DIM));
        write_reg(REG_HEIGHT, CFG_W'(6));
        write_reg(REG_MODE, CFG_W'(MODE_LAPLACE));
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
            begin
                if (r == 2 && c == 2)
                    pix = pixel_t'(16'h8000);
                else if ((r == 2 && (c == 1 || c == 3)) || ((r == 1 || r == 3) && c == 2))
                    pix = pixel_t'(16'h7FFF);
                else
                    pix = '0;
                pixel_queue.push_back(pix);
            end
        wait_drained();
        write_reg(REG_MODE, CFG_W'(MODE_GAUSS));
        for (int c = 0; c < 5; c++)
            pixel_queue.push_back(pixel_t'(16'h8000));
        wait_drained();

        // Random phases: small geometries, mostly whole frames, with register writes
        // (mode, geometry, spare index) between phases and partial frames left behind.
        while (random_sent < RANDOM_ITEMS)
        begin
            geometry_set = (phases == 5) || ($urandom_range(0, 2) == 0);
            if (geometry_set)
            begin
                case ($urandom_range(0, 7))
                    0:       w_raw = CFG_W'($urandom_range(0, MIN_DIM - 1));
                    1:       w_raw = CFG_W'($urandom_range(5, 14)) | (CFG_W'($urandom) & 13'h1800);
                    default: w_raw = CFG_W'($urandom_range(5, 14));
                endcase
                case ($urandom_range(0, 11))
                    0:       h_raw = CFG_W'($urandom_range(0, MIN_DIM - 1));
                    1:       h_raw = 13'h1000 | CFG_W'($urandom_range(0, 4095));
                    default: h_raw = CFG_W'($urandom_range(5, 12));
                endcase
                if ($urandom_range(0, 1))
                begin
                    write_reg(REG_WIDTH, w_raw);
                    write_reg(REG_HEIGHT, h_raw);
                end
                else
                begin
                    write_reg(REG_HEIGHT, h_raw);
                    write_reg(REG_WIDTH, w_raw);
                end
            end
            if ($urandom_range(0, 1))
                write_reg(REG_MODE, CFG_W'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, CFG_W'($urandom));

            // whole frames when the frame start is known, otherwise an arbitrary run
            if (geometry_set && img_height <= 16 && $urandom_range(0, 3) != 0)
                n_items = img_width * img_height * $urandom_range(1, 3);
            else
                n_items = $urandom_range(20, 200);

            // one phase stops the sender halfway until every awaited result is in
            half = (phases == 6) ? n_items / 2 : n_items;
            for (int k = 0; k < half; k++)
                pixel_queue.push_back(draw_pixel());
            if (half != n_items)
            begin
                wait_drained();
                for (int k = half; k < n_items; k++)
                    pixel_queue.push_back(draw_pixel());
            end
            random_sent += n_items;
            wait_drained();
        end

        $display("Run covered %0d pixel transfers and %0d filter results over %0d phases,",
                 pixels_moved, results_seen, phases);
        $display("both filter modes, reset geometry, widths 5 to 32, saturation, mid-frame writes.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
